>>> design/pcc_pkg.sv
// Package for the pixel channel converter: channel count codes, CSR
// register indexes, pixel and configuration structs, luma coefficients.
// No dependencies.
`timescale 1ns / 1ps

package pcc_pkg;

   // Channel count codes
   localparam logic [2:0] CH_GRAY = 3'd1;  // gray
   localparam logic [2:0] CH_GA   = 3'd2;  // gray + alpha
   localparam logic [2:0] CH_RGB  = 3'd3;  // red, green, blue
   localparam logic [2:0] CH_RGBA = 3'd4;  // red, green, blue, alpha

   // CSR register indexes
   localparam logic [1:0] REG_IN_CHANNELS  = 2'd0;
   localparam logic [1:0] REG_OUT_CHANNELS = 2'd1;
   localparam logic [1:0] REG_ALPHA_FILL   = 2'd2;

   // Reset values
   localparam logic [2:0] IN_CHANNELS_RST  = CH_RGB;
   localparam logic [2:0] OUT_CHANNELS_RST = CH_RGBA;
   localparam logic [7:0] ALPHA_FILL_RST   = 8'd255;

   // Rec.709 luma, 16 fractional bits, coefficients sum to 65536
   localparam logic [15:0] LUMA_KR   = 16'd13933;
   localparam logic [15:0] LUMA_KG   = 16'd46871;
   localparam logic [15:0] LUMA_KB   = 16'd4732;
   localparam logic [23:0] LUMA_HALF = 24'd32768;

   typedef struct packed {
      logic [2:0] in_channels;
      logic [2:0] out_channels;
      logic [7:0] alpha_fill;
   } cfg_type;

   typedef struct packed {
      logic [7:0] chan3;
      logic [7:0] chan2;
      logic [7:0] chan1;
      logic [7:0] chan0;
   } pixel_type;

endpackage

>>> design/pcc_csr.sv
// Configuration registers of the pixel channel converter.
// Depends on pcc_pkg.
`timescale 1ns / 1ps

module pcc_csr (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [1:0]      csr_index,
   input  logic [7:0]      csr_data,
   output pcc_pkg::cfg_type cfg
);
   import pcc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken; an index beyond the list changes nothing
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_IN_CHANNELS:  cfg_in.in_channels  = csr_data[2:0];
            REG_OUT_CHANNELS: cfg_in.out_channels = csr_data[2:0];
            REG_ALPHA_FILL:   cfg_in.alpha_fill   = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.in_channels  <= IN_CHANNELS_RST;
         cfg_ff.out_channels <= OUT_CHANNELS_RST;
         cfg_ff.alpha_fill   <= ALPHA_FILL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> design/pcc_convert.sv
// Combinational channel mapping and Rec.709 luma for one pixel.
// Depends on pcc_pkg.
`timescale 1ns / 1ps

module pcc_convert (
   input  pcc_pkg::cfg_type   cfg,
   input  pcc_pkg::pixel_type pix_in,
   output pcc_pkg::pixel_type pix_out,
   output logic               converted
);
   import pcc_pkg::*;

   logic [23:0] luma_sum;
   logic [7:0]  luma;

   // Y = (kr*R + kg*G + kb*B + half) >> 16, never above 255
   assign luma_sum = LUMA_KR * {16'd0, pix_in.chan0}
                   + LUMA_KG * {16'd0, pix_in.chan1}
                   + LUMA_KB * {16'd0, pix_in.chan2}
                   + LUMA_HALF;
   assign luma = luma_sum[23:16];

   // Select output channels by the pair of channel counts
   always_comb begin
      pix_out   = '0;
      converted = 1'b1;
      unique case ({cfg.in_channels, cfg.out_channels})
         {CH_GRAY, CH_GA}: begin
            pix_out.chan0 = pix_in.chan0;
            pix_out.chan1 = cfg.alpha_fill;
         end
         {CH_GRAY, CH_RGB}, {CH_GA, CH_RGB}: begin
            pix_out.chan0 = pix_in.chan0;
            pix_out.chan1 = pix_in.chan0;
            pix_out.chan2 = pix_in.chan0;
         end
         {CH_GRAY, CH_RGBA}: begin
            pix_out.chan0 = pix_in.chan0;
            pix_out.chan1 = pix_in.chan0;
            pix_out.chan2 = pix_in.chan0;
            pix_out.chan3 = cfg.alpha_fill;
         end
         {CH_GA, CH_GRAY}: pix_out.chan0 = pix_in.chan0;
         {CH_GA, CH_RGBA}: begin
            pix_out.chan0 = pix_in.chan0;
            pix_out.chan1 = pix_in.chan0;
            pix_out.chan2 = pix_in.chan0;
            pix_out.chan3 = pix_in.chan1;
         end
         {CH_RGB, CH_GRAY}, {CH_RGBA, CH_GRAY}: pix_out.chan0 = luma;
         {CH_RGB, CH_GA}: begin
            pix_out.chan0 = luma;
            pix_out.chan1 = cfg.alpha_fill;
         end
         {CH_RGB, CH_RGBA}: begin
            pix_out.chan0 = pix_in.chan0;
            pix_out.chan1 = pix_in.chan1;
            pix_out.chan2 = pix_in.chan2;
            pix_out.chan3 = cfg.alpha_fill;
         end
         {CH_RGBA, CH_GA}: begin
            pix_out.chan0 = luma;
            pix_out.chan1 = pix_in.chan3;
         end
         {CH_RGBA, CH_RGB}: begin
            pix_out.chan0 = pix_in.chan0;
            pix_out.chan1 = pix_in.chan1;
            pix_out.chan2 = pix_in.chan2;
         end
         // equal counts or a count out of range: no conversion
         default: converted = 1'b0;
      endcase
   end

endmodule

>>> design/pixel_channel_converter_unit.sv
// Pixel channel converter top: input register, conversion logic, result register.
// Uses pcc_pkg, pcc_csr and pcc_convert.
// Each pixel is held in the input register, then in the result register.
// Throughput: one pixel per cycle; the input stalls only while both stages are
// full and the result transfer is held off.
// Reset: synchronous, active high; clears stage valids, loads in 3, out 4, alpha 255.
`timescale 1ns / 1ps

module pixel_channel_converter_unit (
   input  logic        clock,
   input  logic        reset,
   // Input pixel stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // chan0_in, chan1_in, chan2_in, chan3_in
   input  logic        req_tlast,   // line_end_in
   // Result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // chan0_out, chan1_out, chan2_out, chan3_out
   output logic        rsp_tuser,   // converted
   output logic        rsp_tlast,   // line_end_out
   // Configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);
   import pcc_pkg::*;

   cfg_type   cfg;
   pixel_type conv_pix;
   logic      conv_flag;

   // Input stage
   logic      in_valid_ff, in_valid_in;
   pixel_type in_pix_ff;
   logic      in_last_ff;

   // Result stage
   logic      out_valid_ff, out_valid_in;
   pixel_type out_pix_ff;
   logic      out_conv_ff;
   logic      out_last_ff;

   logic      out_load;
   logic      in_load;

   pcc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pcc_convert u_convert (
      .cfg       (cfg),
      .pix_in    (in_pix_ff),
      .pix_out   (conv_pix),
      .converted (conv_flag)
   );

   // Stage advance control
   assign out_load   = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || out_load;
   assign in_load    = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = in_valid_ff;
      end
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (in_load) begin
         in_pix_ff  <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (out_load && in_valid_ff) begin
         out_pix_ff  <= conv_pix;
         out_conv_ff <= conv_flag;
         out_last_ff <= in_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_pix_ff;
   assign rsp_tuser  = out_conv_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

>>> verif/testbench.sv
// Testbench for pixel_channel_converter_unit: directed and random pixel streams
// over every channel count pairing, checked against a local conversion model.
// Depends on pcc_pkg and the pixel_channel_converter_unit RTL.
`timescale 1ns / 1ps

module testbench;
   import pcc_pkg::*;

   // Counts outside 1..4 and the register index past the end of the list
   localparam logic [2:0] CH_BAD_LOW  = 3'd0;
   localparam logic [2:0] CH_BAD_HIGH = 3'd7;
   localparam logic [1:0] REG_UNUSED  = 2'd3;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      pixel_type chans;
      logic      converted;
      logic      line_end;
   } converted_pixel_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;

   cfg_type             active_cfg;
   converted_pixel_type expected_pixels[$];
   int                  mismatch_count = 0;
   bit                  idle_on = 1'b0;
   int                  stall_left = 0;

   pixel_channel_converter_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Rec.709 luma with 16 fractional bits, rounded half up
   function automatic logic [7:0] luma(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
      int unsigned acc;
      acc = LUMA_KR * r + LUMA_KG * g + LUMA_KB * b + LUMA_HALF;
      return acc[23:16];
   endfunction

   // Expected output pixel for the current channel counts
   function automatic converted_pixel_type convert_pixel(input pixel_type px,
                                                         input logic last);
      converted_pixel_type res;
      res = '0;
      res.converted = 1'b1;
      res.line_end = last;
      case ({active_cfg.in_channels, active_cfg.out_channels})
         {CH_GRAY, CH_GA}: begin
            res.chans.chan0 = px.chan0;
            res.chans.chan1 = active_cfg.alpha_fill;
         end
         {CH_GRAY, CH_RGB}, {CH_GA, CH_RGB}: begin
            res.chans.chan0 = px.chan0;
            res.chans.chan1 = px.chan0;
            res.chans.chan2 = px.chan0;
         end
         {CH_GRAY, CH_RGBA}: begin
            res.chans.chan0 = px.chan0;
            res.chans.chan1 = px.chan0;
            res.chans.chan2 = px.chan0;
            res.chans.chan3 = active_cfg.alpha_fill;
         end
         {CH_GA, CH_GRAY}: res.chans.chan0 = px.chan0;
         {CH_GA, CH_RGBA}: begin
            res.chans.chan0 = px.chan0;
            res.chans.chan1 = px.chan0;
            res.chans.chan2 = px.chan0;
            res.chans.chan3 = px.chan1;
         end
         {CH_RGB, CH_GRAY}, {CH_RGBA, CH_GRAY}:
            res.chans.chan0 = luma(px.chan0, px.chan1, px.chan2);
         {CH_RGB, CH_GA}: begin
            res.chans.chan0 = luma(px.chan0, px.chan1, px.chan2);
            res.chans.chan1 = active_cfg.alpha_fill;
         end
         {CH_RGB, CH_RGBA}: begin
            res.chans.chan0 = px.chan0;
            res.chans.chan1 = px.chan1;
            res.chans.chan2 = px.chan2;
            res.chans.chan3 = active_cfg.alpha_fill;
         end
         {CH_RGBA, CH_GA}: begin
            res.chans.chan0 = luma(px.chan0, px.chan1, px.chan2);
            res.chans.chan1 = px.chan3;
         end
         {CH_RGBA, CH_RGB}: begin
            res.chans.chan0 = px.chan0;
            res.chans.chan1 = px.chan1;
            res.chans.chan2 = px.chan2;
         end
         // equal or out-of-range counts: nothing converted
         default: res.converted = 1'b0;
      endcase
      return res;
   endfunction

   // Mostly random bytes, with the extremes turning up often
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type px;
      px.chan0 = pick_byte();
      px.chan1 = pick_byte();
      px.chan2 = pick_byte();
      px.chan3 = pick_byte();
      return px;
   endfunction

   // One pixel transfer; the expected result is queued once it is accepted
   task automatic send_pixel(input pixel_type px, input logic last);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      expected_pixels.push_back(convert_pixel(px, last));
   endtask

   task automatic send_random(input int count);
      repeat (count) send_pixel(random_pixel(), 1'($urandom));
   endtask

   // Stop the stream and wait until every result is back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_IN_CHANNELS:  active_cfg.in_channels  = value[2:0];
         REG_OUT_CHANNELS: active_cfg.out_channels = value[2:0];
         REG_ALPHA_FILL:   active_cfg.alpha_fill   = value;
         default: ;
      endcase
   endtask

   // Program all three registers; unused upper data bits carry noise
   task automatic set_mode(input logic [2:0] in_ch, input logic [2:0] out_ch,
                           input logic [7:0] alpha);
      logic [4:0] noise_in;
      logic [4:0] noise_out;
      noise_in  = 5'($urandom);
      noise_out = 5'($urandom);
      write_reg(REG_IN_CHANNELS, {noise_in, in_ch});
      write_reg(REG_OUT_CHANNELS, {noise_out, out_ch});
      write_reg(REG_ALPHA_FILL, alpha);
      csr_valid <= 1'b0;
   endtask

   // Result stall bursts on the sink side
   always @(posedge clock) begin
      if (reset || !idle_on) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 5);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each result transfer with the oldest expectation
   always @(posedge clock) begin : result_check
      converted_pixel_type want;
      converted_pixel_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata, rsp_tuser, rsp_tlast};
         if (expected_pixels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result: data %h conv %b last %b",
                        got.chans, got.converted, got.line_end);
         end else begin
            want = expected_pixels.pop_front();
            if (got.chans.chan0 !== want.chans.chan0 ||
                got.chans.chan1 !== want.chans.chan1 ||
                got.chans.chan2 !== want.chans.chan2 ||
                got.chans.chan3 !== want.chans.chan3 ||
                got.converted !== want.converted ||
                got.line_end !== want.line_end) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display({"mismatch: expected data %h conv %b last %b, ",
                            "got data %h conv %b last %b"},
                           want.chans, want.converted, want.line_end,
                           got.chans, got.converted, got.line_end);
            end
         end
      end
   end

   // Reset mode (RGB to RGBA, opaque fill) with extreme and mixed pixels
   task automatic test_reset_mode();
      send_pixel(32'h0000_0000, 1'b0);
      send_pixel(32'hFFFF_FFFF, 1'b1);
      send_pixel(32'h1234_5678, 1'b0);
      send_pixel(32'hA5A5_A55A, 1'b1);
      drain();
   endtask

   // Luma path: primaries, white, black; alpha kept or ignored for RGBA input
   task automatic test_luma();
      set_mode(CH_RGB, CH_GRAY, 8'h00);
      send_pixel(32'h00FF_FFFF, 1'b0);
      send_pixel(32'hFF00_0000, 1'b1);
      send_pixel(32'h0000_00FF, 1'b0);
      send_pixel(32'h0000_FF00, 1'b0);
      send_pixel(32'h00FF_0000, 1'b1);
      drain();
      set_mode(CH_RGBA, CH_GA, 8'h00);
      send_pixel(32'hFF1E_C80A, 1'b0);
      send_pixel(32'h001E_C80A, 1'b1);
      drain();
      set_mode(CH_RGBA, CH_GRAY, 8'hFF);
      send_pixel(32'hFF1E_C80A, 1'b0);
      send_pixel(32'h001E_C80A, 1'b1);
      drain();
   endtask

   // Gray replication, alpha fill, alpha kept and alpha dropped
   task automatic test_expand_and_drop();
      set_mode(CH_GRAY, CH_RGBA, 8'h00);
      send_pixel(32'hFFFF_FF80, 1'b1);
      drain();
      set_mode(CH_GA, CH_RGBA, 8'hFF);
      send_pixel(32'h0000_3C7F, 1'b0);
      drain();
      set_mode(CH_GA, CH_GRAY, 8'h55);
      send_pixel(32'hFFFF_FF01, 1'b1);
      drain();
      set_mode(CH_RGBA, CH_RGB, 8'hAA);
      send_pixel(32'hEE33_2211, 1'b0);
      drain();
   endtask

   // Equal counts and counts outside 1..4 give nothing converted
   task automatic test_no_conversion();
      set_mode(CH_RGB, CH_RGB, 8'h80);
      send_pixel(32'hFFFF_FFFF, 1'b1);
      drain();
      set_mode(CH_BAD_LOW, CH_GA, 8'h80);
      send_pixel(32'hFFFF_FFFF, 1'b0);
      drain();
      set_mode(CH_RGBA, CH_BAD_HIGH, 8'h80);
      send_pixel(32'hFFFF_FFFF, 1'b1);
      drain();
   endtask

   // A write past the last register must leave the mode alone
   task automatic test_unused_index();
      set_mode(CH_RGB, CH_GA, 8'h3C);
      write_reg(REG_UNUSED, 8'hFF);
      write_reg(REG_UNUSED, 8'h00);
      csr_valid <= 1'b0;
      send_pixel(32'h0040_8020, 1'b0);
      send_pixel(32'h00FF_FFFF, 1'b1);
      drain();
   endtask

   // Every in/out pairing, 0..7 each, with random fill and idling on and off
   task automatic test_mode_sweep();
      logic [7:0] alpha;
      for (int i = 0; i < 8; i++) begin
         for (int o = 0; o < 8; o++) begin
            case ($urandom_range(0, 3))
               0: alpha = 8'h00;
               1: alpha = 8'hFF;
               default: alpha = 8'($urandom);
            endcase
            idle_on = ($urandom_range(0, 3) != 0);
            set_mode(3'(i), 3'(o), alpha);
            if (i >= 1 && i <= 4 && o >= 1 && o <= 4)
               send_random(24);
            else
               send_random(3);
            drain();
         end
      end
   endtask

   // Closing stretch at full rate, no idling on either side
   task automatic test_full_rate();
      idle_on = 1'b0;
      set_mode(3'($urandom_range(1, 4)), 3'($urandom_range(1, 4)), 8'($urandom));
      send_random(30);
      drain();
   endtask

   initial begin
      active_cfg.in_channels  = IN_CHANNELS_RST;
      active_cfg.out_channels = OUT_CHANNELS_RST;
      active_cfg.alpha_fill   = ALPHA_FILL_RST;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reset_mode();
      idle_on = 1'b1;
      test_luma();
      test_expand_and_drop();
      test_no_conversion();
      test_unused_index();
      test_mode_sweep();
      test_full_rate();

      repeat (8) @(posedge clock);
      if (expected_pixels.size() != 0) begin
         mismatch_count++;
         $display("%0d expected results never arrived", expected_pixels.size());
      end
      if (mismatch_count == 0) begin
         $display("pixel_channel_converter_unit test passed");
      end else begin
         $display("pixel_channel_converter_unit test failed");
      end
      $finish;
   end

   // Watchdog against a hung handshake
   initial begin
      #3_000_000;
      $display("pixel_channel_converter_unit test failed");
      $finish;
   end

endmodule

>>> files.f
design/pcc_pkg.sv
design/pcc_csr.sv
design/pcc_convert.sv
design/pixel_channel_converter_unit.sv
verif/testbench.sv
